/* design/sl1d_pkg.sv */
`timescale 1ns / 1ps

package sl1d_pkg;

  // default sizing of the sorting chains
  localparam int unsigned MaxPairsDef  = 1024;
  localparam int unsigned ValueBitsDef = 20;

  // result field widths
  localparam int unsigned TotalBits = 31;
  localparam int unsigned PairsBits = 11;

  localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};

  // control broadcast to every cell of a chain
  typedef struct packed {
    logic ins;    // insert the broadcast value in order
    logic shift;  // move every entry one cell toward the head
  } sl1d_ctrl_t;

endpackage

/* design/sl1d_cell.sv */
`timescale 1ns / 1ps

module sl1d_cell #(
  parameter int unsigned Idx       = 0,
  parameter int unsigned ValueBits = sl1d_pkg::ValueBitsDef,
  parameter int unsigned CntBits   = 11
) (
  input  logic                 clk_i,
  input  sl1d_pkg::sl1d_ctrl_t ctrl_i,
  input  logic [CntBits-1:0]   count_i,
  input  logic [ValueBits-1:0] ins_val_i,
  input  logic                 prev_gt_i,
  input  logic [ValueBits-1:0] prev_val_i,
  input  logic [ValueBits-1:0] next_val_i,
  output logic [ValueBits-1:0] val_o,
  output logic                 gt_o
);
  import sl1d_pkg::*;

  logic [ValueBits-1:0] val_q, val_d;
  logic                 occ;

  // an empty cell acts as larger than any value
  always_comb begin
    occ  = CntBits'(Idx) < count_i;
    gt_o = !occ || (val_q > ins_val_i);
  end

  // insert: take the neighbor's entry or the new value; drain: shift toward head
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.ins && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : ins_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* design/sl1d_chain.sv */
`timescale 1ns / 1ps

module sl1d_chain #(
  parameter int unsigned MaxPairs  = sl1d_pkg::MaxPairsDef,
  parameter int unsigned ValueBits = sl1d_pkg::ValueBitsDef,
  parameter int unsigned CntBits   = $clog2(MaxPairs + 1)
) (
  input  logic                 clk_i,
  input  sl1d_pkg::sl1d_ctrl_t ctrl_i,
  input  logic [CntBits-1:0]   count_i,
  input  logic [ValueBits-1:0] ins_val_i,
  output logic [ValueBits-1:0] head_val_o
);
  import sl1d_pkg::*;

  logic [ValueBits-1:0] vals [MaxPairs];
  logic                 gts  [MaxPairs];

  // row of cells, sorted ascending from the head
  for (genvar i = 0; i < MaxPairs; i++) begin : g_cell
    logic                 prev_gt;
    logic [ValueBits-1:0] prev_val;
    logic [ValueBits-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = ins_val_i;
    end else begin : g_body
      assign prev_gt  = gts[i-1];
      assign prev_val = vals[i-1];
    end

    if (i == MaxPairs - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end

    sl1d_cell #(
      .Idx      (i),
      .ValueBits(ValueBits),
      .CntBits  (CntBits)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .count_i   (count_i),
      .ins_val_i (ins_val_i),
      .prev_gt_i (prev_gt),
      .prev_val_i(prev_val),
      .next_val_i(next_val),
      .val_o     (vals[i]),
      .gt_o      (gts[i])
    );
  end

  assign head_val_o = vals[0];

endmodule

/* design/sorted_list_l1_distance.sv */
`timescale 1ns / 1ps
// result: after the pair flagged last, both chains drain with one shift per stored
//   pair and the differences are summed before the result is shown
// throughput: one pair per cycle while loading; input stalls during the drain of
//   the two insertion chains and, at the finish, while a previous result still waits
// reset: asynchronous, clears counters, flags and handshake state; chain cells hold data only

module sorted_list_l1_distance #(
  parameter int unsigned MaxPairs  = sl1d_pkg::MaxPairsDef,
  parameter int unsigned ValueBits = sl1d_pkg::ValueBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ValueBits-1:0]           left_value_i,
  input  logic [ValueBits-1:0]           right_value_i,
  input  logic                           last_pair_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sl1d_pkg::TotalBits-1:0] total_distance_o,
  output logic [sl1d_pkg::PairsBits-1:0] pairs_used_o,
  output logic                           overflow_o
);
  import sl1d_pkg::*;

  localparam int unsigned CntBits = $clog2(MaxPairs + 1);
  localparam int unsigned SumBits = TotalBits + 2;

  localparam logic [1:0] StLoad   = 2'd0;
  localparam logic [1:0] StDrain  = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic [CntBits-1:0]   rem_q, rem_d;
  logic                 dropped_q, dropped_d;
  logic                 dv_q, dv_d;
  logic [ValueBits-1:0] diff_q, diff_d;
  logic [TotalBits-1:0] acc_q, acc_d;
  logic                 sat_q, sat_d;
  logic                 out_valid_q, out_valid_d;
  logic [TotalBits-1:0] total_q, total_d;
  logic [PairsBits-1:0] pairs_q, pairs_d;
  logic                 ovf_q, ovf_d;

  sl1d_ctrl_t           ctrl;
  logic                 in_xfer;
  logic                 has_room;
  logic [ValueBits-1:0] left_head, right_head;
  logic [SumBits-1:0]   sum;

  // insertion chains
  sl1d_chain #(
    .MaxPairs (MaxPairs),
    .ValueBits(ValueBits),
    .CntBits  (CntBits)
  ) u_left (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .count_i   (count_q),
    .ins_val_i (left_value_i),
    .head_val_o(left_head)
  );

  sl1d_chain #(
    .MaxPairs (MaxPairs),
    .ValueBits(ValueBits),
    .CntBits  (CntBits)
  ) u_right (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .count_i   (count_q),
    .ins_val_i (right_value_i),
    .head_val_o(right_head)
  );

  assign in_ready_o = (state_q == StLoad);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign has_room   = count_q < CntBits'(MaxPairs);

  // chain control
  always_comb begin
    ctrl.ins   = in_xfer && has_room;
    ctrl.shift = (state_q == StDrain) && (rem_q != '0);
  end

  // saturating accumulate of the registered difference
  assign sum = SumBits'(acc_q) + SumBits'(diff_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    dropped_d   = dropped_q;
    dv_d        = 1'b0;
    diff_d      = diff_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    pairs_d     = pairs_q;
    ovf_d       = ovf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (dv_q) begin
      if (sum > SumBits'(TotalMax)) begin
        acc_d = TotalMax;
        sat_d = 1'b1;
      end else begin
        acc_d = sum[TotalBits-1:0];
      end
    end

    unique case (state_q)
      StLoad: begin
        if (in_xfer) begin
          if (has_room) begin
            count_d = count_q + CntBits'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_pair_i) begin
            rem_d   = has_room ? count_q + CntBits'(1) : count_q;
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (rem_q != '0) begin
          diff_d = (left_head >= right_head) ? left_head - right_head
                                             : right_head - left_head;
          dv_d   = 1'b1;
          rem_d  = rem_q - CntBits'(1);
        end else if (!dv_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          total_d     = acc_q;
          pairs_d     = PairsBits'(count_q);
          ovf_d       = dropped_q || sat_q;
          acc_d       = '0;
          sat_d       = 1'b0;
          count_d     = '0;
          dropped_d   = 1'b0;
          state_d     = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      rem_q       <= '0;
      dropped_q   <= 1'b0;
      dv_q        <= 1'b0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      dropped_q   <= dropped_d;
      dv_q        <= dv_d;
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    total_q <= total_d;
    pairs_q <= pairs_d;
    ovf_q   <= ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign total_distance_o = total_q;
  assign pairs_used_o     = pairs_q;
  assign overflow_o       = ovf_q;

endmodule
